>>> rtl/vcdf_pkg.sv
// Package for the voxel CDF point sampler: field widths, command codes,
// configuration register indexes and the divider status record.
// Depends on nothing; the core, the divider and the checker import it.
package vcdf_pkg;

    // Widths of the fixed fields of the input, result and configuration words.
    localparam int CNT_W    = 13;
    localparam int EXT_W    = 20;
    localparam int PIN_W    = 24;
    localparam int IDX_W    = 12;
    localparam int JIT_W    = 8;
    localparam int POS_W    = 21;
    localparam int CFG_AW   = 3;
    localparam int CFG_DW   = 20;

    // Magnitude of extent * (2n - count) + count never reaches 2^34.
    localparam int AX_NW    = 34;
    // Divisor of the axis scaling is twice a grid count.
    localparam int AX_DW    = CNT_W + 1;

    localparam logic signed [POS_W+2:0] POS_HI = 24'sd1048575;
    localparam logic signed [POS_W+2:0] POS_LO = -24'sd1048576;

    // Command codes of an input word.
    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_AW-1:0] REG_GRID_X = 3'd0;
    localparam logic [CFG_AW-1:0] REG_GRID_Y = 3'd1;
    localparam logic [CFG_AW-1:0] REG_GRID_Z = 3'd2;
    localparam logic [CFG_AW-1:0] REG_EXT_X  = 3'd3;
    localparam logic [CFG_AW-1:0] REG_EXT_Y  = 3'd4;
    localparam logic [CFG_AW-1:0] REG_EXT_Z  = 3'd5;

    // Handshake between the sequencer and a divider.
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

>>> rtl/voxel_cdf_point_sampler_core.sv
// Load word: written to the table while idle; the next word is taken in the
// following cycle. Sample word: a binary search over the searched length (the
// grid size, capped at the table depth) through the table read port, then the
// bit-serial index and axis dividers. One sample is worked on at a time.
// Reset clears control and configuration; the table is undefined until written.
module voxel_cdf_point_sampler_core
    import vcdf_pkg::*;
#(
    parameter int TABLE_DEPTH = 4096,
    parameter int PROB_BITS   = 24
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    // Input words
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_command,
    input  logic [IDX_W-1:0]         s_entry_index,
    input  logic [PIN_W-1:0]         s_entry_value,
    input  logic [PIN_W-1:0]         s_uniform_draw,
    input  logic signed [JIT_W-1:0]  s_jitter_x,
    input  logic signed [JIT_W-1:0]  s_jitter_y,
    input  logic signed [JIT_W-1:0]  s_jitter_z,
    // Result words
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [POS_W-1:0]  m_pos_x,
    output logic signed [POS_W-1:0]  m_pos_y,
    output logic signed [POS_W-1:0]  m_pos_z,
    output logic [IDX_W-1:0]         m_voxel_index,
    output logic                     m_search_failed,
    // Configuration writes
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_AW-1:0]        cfg_index,
    input  logic [CFG_DW-1:0]        cfg_data
);

    localparam int AW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNTW = AW + 1;
    localparam int QW   = (AW < 2) ? 2 : AW;
    localparam int CW   = (PROB_BITS > PIN_W) ? PROB_BITS : PIN_W;
    localparam int TW   = 3 * CNT_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CNT,
        S_FIRST,
        S_SADDR,
        S_SCMP,
        S_ZDIV_GO,
        S_ZDIV_WAIT,
        S_YDIV_GO,
        S_YDIV_WAIT,
        S_MUL,
        S_AXDIV_GO,
        S_AXDIV_WAIT,
        S_DONE
    } state_t;

    // Floor of the signed quotient, plus jitter, saturated to the result width.
    function automatic logic signed [POS_W-1:0] axis_pos(
        input logic [AX_NW-1:0]        q,
        input logic                    r_nz,
        input logic                    neg,
        input logic signed [JIT_W-1:0] jit
    );
        logic signed [POS_W+2:0] mag;
        logic signed [POS_W+2:0] base;
        logic signed [POS_W+2:0] sum;
        logic signed [POS_W-1:0] res;
        mag  = $signed({2'b00, q[POS_W:0]});
        base = neg ? (-mag - $signed({{(POS_W+2){1'b0}}, r_nz})) : mag;
        sum  = base + $signed({{(POS_W+3-JIT_W){jit[JIT_W-1]}}, jit});
        if (sum > POS_HI) begin
            res = POS_HI[POS_W-1:0];
        end else if (sum < POS_LO) begin
            res = POS_LO[POS_W-1:0];
        end else begin
            res = sum[POS_W-1:0];
        end
        return res;
    endfunction

    state_t state_reg;

    // Configuration registers.
    logic [CNT_W-1:0] cnt_x_reg, cnt_y_reg, cnt_z_reg;
    logic [EXT_W-1:0] ext_x_reg, ext_y_reg, ext_z_reg;

    // Sample word and search state.
    logic [PIN_W-1:0]        draw_reg;
    logic signed [JIT_W-1:0] jit_x_reg, jit_y_reg, jit_z_reg;
    logic [2*CNT_W-1:0]      yz_reg;
    logic [TW-1:0]           total_reg;
    logic [CNTW-1:0]         len_reg;
    logic [CNTW-1:0]         lo_reg, hi_reg, mid_reg;
    logic [AW-1:0]           sel_reg;
    logic                    fail_reg;
    logic [CNT_W-1:0]        nx_reg, ny_reg, nz_reg;
    logic signed [35:0]      prod_x_reg, prod_y_reg, prod_z_reg;
    logic                    neg_x_reg, neg_y_reg, neg_z_reg;

    // Output register.
    logic                    m_valid_reg;
    logic signed [POS_W-1:0] pos_x_reg, pos_y_reg, pos_z_reg;
    logic [IDX_W-1:0]        vidx_reg;
    logic                    failed_reg;

    // Table ports.
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [PROB_BITS-1:0] wr_data;
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic [PROB_BITS-1:0] rd_data;

    // Divider ports.
    logic                idx_start;
    logic [QW-1:0]       idx_dividend;
    logic [CNT_W-1:0]    idx_divisor;
    div_stat_t           idx_stat;
    logic [QW-1:0]       idx_quo;
    logic [CNT_W-1:0]    idx_rem;

    logic                ax_start;
    logic [AX_NW-1:0]    ax_mag_x, ax_mag_y, ax_mag_z;
    div_stat_t           ax_stat_x, ax_stat_y, ax_stat_z;
    logic [AX_NW-1:0]    ax_quo_x, ax_quo_y, ax_quo_z;
    logic [AX_DW-1:0]    ax_rem_x, ax_rem_y, ax_rem_z;
    logic signed [36:0]  ax_sum_x, ax_sum_y, ax_sum_z;

    logic                s_fire;
    logic                m_free;
    logic [CNTW-1:0]     len_now;
    logic                hit;
    logic [CNTW:0]       mid_sum;

    assign s_ready   = (state_reg == S_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign m_free    = !m_valid_reg || m_ready;

    // Searched length: the grid size, capped at the table depth.
    assign len_now = (total_reg < TW'(TABLE_DEPTH)) ? CNTW'(total_reg) : CNTW'(TABLE_DEPTH);
    assign hit     = (CW'(rd_data) <= CW'(draw_reg));
    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};

    // Table access. Loads are written only while idle, so the search never
    // reads an entry in the same cycle it is written.
    assign wr_en   = s_fire && (s_command == CMD_LOAD) &&
                     ({{(CNTW+IDX_W){1'b0}}, s_entry_index} < (CNTW+IDX_W)'(TABLE_DEPTH));
    assign wr_addr = AW'(s_entry_index);
    assign wr_data = PROB_BITS'(s_entry_value);
    assign rd_en   = (state_reg == S_CNT) || ((state_reg == S_SADDR) && (lo_reg < hi_reg));
    assign rd_addr = (state_reg == S_CNT) ? '0 : AW'(mid_sum >> 1);

    vcdf_table #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW),
        .DW    (PROB_BITS)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Index split: sel / count_z first, then that quotient / count_y.
    assign idx_start    = (state_reg == S_ZDIV_GO) || (state_reg == S_YDIV_GO);
    assign idx_dividend = (state_reg == S_YDIV_GO) ? idx_quo : QW'(sel_reg);
    assign idx_divisor  = (state_reg == S_YDIV_GO) ? cnt_y_reg : cnt_z_reg;

    vcdf_div #(
        .NW (QW),
        .DW (CNT_W)
    ) u_idx_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (idx_start),
        .dividend  (idx_dividend),
        .divisor   (idx_divisor),
        .stat      (idx_stat),
        .quotient  (idx_quo),
        .remainder (idx_rem)
    );

    // Axis scaling: extent * (2n - count) + count over 2 * count, floored.
    assign ax_start = (state_reg == S_AXDIV_GO);
    assign ax_sum_x = {prod_x_reg[35], prod_x_reg} + $signed({24'b0, cnt_x_reg});
    assign ax_sum_y = {prod_y_reg[35], prod_y_reg} + $signed({24'b0, cnt_y_reg});
    assign ax_sum_z = {prod_z_reg[35], prod_z_reg} + $signed({24'b0, cnt_z_reg});
    assign ax_mag_x = ax_sum_x[36] ? AX_NW'(-ax_sum_x) : AX_NW'(ax_sum_x);
    assign ax_mag_y = ax_sum_y[36] ? AX_NW'(-ax_sum_y) : AX_NW'(ax_sum_y);
    assign ax_mag_z = ax_sum_z[36] ? AX_NW'(-ax_sum_z) : AX_NW'(ax_sum_z);

    vcdf_div #(
        .NW (AX_NW),
        .DW (AX_DW)
    ) u_ax_div_x (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (ax_start),
        .dividend  (ax_mag_x),
        .divisor   ({cnt_x_reg, 1'b0}),
        .stat      (ax_stat_x),
        .quotient  (ax_quo_x),
        .remainder (ax_rem_x)
    );

    vcdf_div #(
        .NW (AX_NW),
        .DW (AX_DW)
    ) u_ax_div_y (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (ax_start),
        .dividend  (ax_mag_y),
        .divisor   ({cnt_y_reg, 1'b0}),
        .stat      (ax_stat_y),
        .quotient  (ax_quo_y),
        .remainder (ax_rem_y)
    );

    vcdf_div #(
        .NW (AX_NW),
        .DW (AX_DW)
    ) u_ax_div_z (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (ax_start),
        .dividend  (ax_mag_z),
        .divisor   ({cnt_z_reg, 1'b0}),
        .stat      (ax_stat_z),
        .quotient  (ax_quo_z),
        .remainder (ax_rem_z)
    );

    // Configuration registers; indexes beyond the list are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_x_reg <= CNT_W'(16);
            cnt_y_reg <= CNT_W'(16);
            cnt_z_reg <= CNT_W'(16);
            ext_x_reg <= '0;
            ext_y_reg <= '0;
            ext_z_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_GRID_X: cnt_x_reg <= cfg_data[CNT_W-1:0];
                REG_GRID_Y: cnt_y_reg <= cfg_data[CNT_W-1:0];
                REG_GRID_Z: cnt_z_reg <= cfg_data[CNT_W-1:0];
                REG_EXT_X:  ext_x_reg <= cfg_data[EXT_W-1:0];
                REG_EXT_Y:  ext_y_reg <= cfg_data[EXT_W-1:0];
                REG_EXT_Z:  ext_z_reg <= cfg_data[EXT_W-1:0];
                default:    ;
            endcase
        end
    end

    // Sequencer: search, index split, axis scaling and the output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_fire && (s_command == CMD_SAMPLE)) begin
                        draw_reg  <= s_uniform_draw;
                        jit_x_reg <= s_jitter_x;
                        jit_y_reg <= s_jitter_y;
                        jit_z_reg <= s_jitter_z;
                        yz_reg    <= cnt_y_reg * cnt_z_reg;
                        state_reg <= S_CNT;
                    end
                end
                S_CNT: begin
                    total_reg <= yz_reg * cnt_x_reg;
                    state_reg <= S_FIRST;
                end
                S_FIRST: begin
                    // Entry 0 above the draw, or an empty grid, fails at once.
                    len_reg <= len_now;
                    lo_reg  <= '0;
                    hi_reg  <= len_now;
                    if ((len_now == '0) || !hit) begin
                        fail_reg  <= 1'b1;
                        state_reg <= S_DONE;
                    end else begin
                        fail_reg  <= 1'b0;
                        state_reg <= S_SADDR;
                    end
                end
                S_SADDR: begin
                    if (lo_reg < hi_reg) begin
                        mid_reg   <= CNTW'(mid_sum >> 1);
                        state_reg <= S_SCMP;
                    end else if ((lo_reg != '0) && (lo_reg < len_reg)) begin
                        sel_reg   <= AW'(lo_reg - 1'b1);
                        state_reg <= S_ZDIV_GO;
                    end else begin
                        fail_reg  <= 1'b1;
                        state_reg <= S_DONE;
                    end
                end
                S_SCMP: begin
                    if (hit) begin
                        lo_reg <= mid_reg + 1'b1;
                    end else begin
                        hi_reg <= mid_reg;
                    end
                    state_reg <= S_SADDR;
                end
                S_ZDIV_GO: begin
                    state_reg <= S_ZDIV_WAIT;
                end
                S_ZDIV_WAIT: begin
                    if (idx_stat.done) begin
                        nz_reg    <= idx_rem;
                        state_reg <= S_YDIV_GO;
                    end
                end
                S_YDIV_GO: begin
                    state_reg <= S_YDIV_WAIT;
                end
                S_YDIV_WAIT: begin
                    if (idx_stat.done) begin
                        nx_reg    <= CNT_W'(idx_quo);
                        ny_reg    <= idx_rem;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL: begin
                    prod_x_reg <= $signed({1'b0, ext_x_reg}) *
                                  ($signed({1'b0, nx_reg, 1'b0}) - $signed({2'b0, cnt_x_reg}));
                    prod_y_reg <= $signed({1'b0, ext_y_reg}) *
                                  ($signed({1'b0, ny_reg, 1'b0}) - $signed({2'b0, cnt_y_reg}));
                    prod_z_reg <= $signed({1'b0, ext_z_reg}) *
                                  ($signed({1'b0, nz_reg, 1'b0}) - $signed({2'b0, cnt_z_reg}));
                    state_reg  <= S_AXDIV_GO;
                end
                S_AXDIV_GO: begin
                    neg_x_reg <= ax_sum_x[36];
                    neg_y_reg <= ax_sum_y[36];
                    neg_z_reg <= ax_sum_z[36];
                    state_reg <= S_AXDIV_WAIT;
                end
                S_AXDIV_WAIT: begin
                    // The three dividers run in lockstep.
                    if (ax_stat_x.done) begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (m_free) begin
                        m_valid_reg <= 1'b1;
                        failed_reg  <= fail_reg;
                        if (fail_reg) begin
                            pos_x_reg <= '0;
                            pos_y_reg <= '0;
                            pos_z_reg <= '0;
                            vidx_reg  <= '0;
                        end else begin
                            pos_x_reg <= axis_pos(ax_quo_x, ax_rem_x != '0, neg_x_reg, jit_x_reg);
                            pos_y_reg <= axis_pos(ax_quo_y, ax_rem_y != '0, neg_y_reg, jit_y_reg);
                            pos_z_reg <= axis_pos(ax_quo_z, ax_rem_z != '0, neg_z_reg, jit_z_reg);
                            vidx_reg  <= IDX_W'(sel_reg);
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_pos_x         = pos_x_reg;
    assign m_pos_y         = pos_y_reg;
    assign m_pos_z         = pos_z_reg;
    assign m_voxel_index   = vidx_reg;
    assign m_search_failed = failed_reg;

    // Status bits the sequencer does not need beyond done.
    logic unused_busy;
    assign unused_busy = idx_stat.busy ^ ax_stat_x.busy ^ ax_stat_y.busy ^ ax_stat_z.busy ^
                         ax_stat_y.done ^ ax_stat_z.done;

endmodule

>>> rtl/vcdf_table.sv
// Table memory of the voxel CDF point sampler: one write port, one read
// port with registered read data. Depends on no package.
module vcdf_table #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12,
    parameter int DW    = 24
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port with registered read data.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/vcdf_div.sv
// Restoring unsigned divider of the voxel CDF point sampler, one quotient
// bit per cycle. Depends on vcdf_pkg for the status record.
module vcdf_div
    import vcdf_pkg::*;
#(
    parameter int NW = 16,
    parameter int DW = 13
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [NW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    output div_stat_t     stat,
    output logic [NW-1:0] quotient,
    output logic [DW-1:0] remainder
);

    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] quo_reg;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] div_reg;
    logic [CW-1:0] count_reg;
    logic          busy_reg;
    logic          done_reg;

    logic [DW:0]   trial;
    logic          take;
    logic [DW:0]   diff;

    // One trial subtraction: bring down the next dividend bit.
    always_comb begin
        trial = {rem_reg, quo_reg[NW-1]};
        diff  = trial - {1'b0, div_reg};
        take  = (trial >= {1'b0, div_reg});
    end

    // Iteration control and the shifting quotient register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg  <= 1'b1;
                count_reg <= CW'(NW);
            end else if (busy_reg) begin
                count_reg <= count_reg - 1'b1;
                if (count_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath registers need no reset.
    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= NW'({quo_reg, take});
            rem_reg <= take ? diff[DW-1:0] : trial[DW-1:0];
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

>>> rtl/vcdf_checker.sv
// Port-level checks for the voxel CDF point sampler, bound to the top level.
// Depends on vcdf_pkg for field widths and command codes.
module vcdf_checker
    import vcdf_pkg::*;
(
    input logic                    aclk,
    input logic                    aresetn,
    input logic                    s_valid,
    input logic                    s_ready,
    input logic                    s_command,
    input logic                    m_valid,
    input logic                    m_ready,
    input logic signed [POS_W-1:0] m_pos_x,
    input logic signed [POS_W-1:0] m_pos_y,
    input logic signed [POS_W-1:0] m_pos_z,
    input logic [IDX_W-1:0]        m_voxel_index,
    input logic                    m_search_failed
);

    // No result word is offered in the cycle after reset.
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result word offered straight after reset");

    // A failed search reports a zero position and index.
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_search_failed) |->
            (m_pos_x == '0) && (m_pos_y == '0) && (m_pos_z == '0) && (m_voxel_index == '0))
        else $error("failed search with a non-zero position or index");

    // A load word never produces a result word.
    a_load_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_command == CMD_LOAD) && !m_valid) |=> !m_valid)
        else $error("load word produced a result word");

    // A stalled result word holds its contents.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=>
            m_valid && $stable(m_pos_x) && $stable(m_pos_y) && $stable(m_pos_z) &&
            $stable(m_voxel_index) && $stable(m_search_failed))
        else $error("stalled result word changed");

endmodule

bind voxel_cdf_point_sampler_core vcdf_checker u_vcdf_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .s_command       (s_command),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_pos_x         (m_pos_x),
    .m_pos_y         (m_pos_y),
    .m_pos_z         (m_pos_z),
    .m_voxel_index   (m_voxel_index),
    .m_search_failed (m_search_failed)
);
